FILE: src/m64h_pkg.sv
// Package for the MurmurHash64A stream hash unit.
// Shared constants, queue item type, state encodings and the shift-xor helper.
// No dependencies.
package m64h_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned LenW  = 32;
  localparam int unsigned NbW   = 4;

  localparam logic [WordW-1:0] MurMult   = 64'hc6a4a7935bd1e995;
  localparam int unsigned      MurShift  = 47;
  localparam logic [NbW-1:0]   WordBytes = 4'd8;

  localparam int unsigned QueueDepthDef = 2;

  typedef enum logic [1:0] {
    WK_NONE,
    WK_TAIL,
    WK_FULL
  } word_kind_e;

  typedef struct packed {
    logic [WordW-1:0] data;
    word_kind_e       kind;
    logic             first;
    logic             last;
    logic [LenW-1:0]  length;
  } work_item_t;

  typedef struct packed {
    logic       valid;
    work_item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_LEN_MUL,
    BS_K_MUL1,
    BS_K_MUL2,
    BS_ACC_MUL,
    BS_FIN_MUL,
    BS_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_LO,
    MS_MID1,
    MS_MID2
  } mul_step_e;

  function automatic logic [WordW-1:0] shift_xor(input logic [WordW-1:0] v);
    return v ^ (v >> MurShift);
  endfunction

endpackage

FILE: src/m64h_front.sv
// Front end of the hash unit: accepts items, masks and classifies words,
// drops items outside a message and queues the rest. Uses m64h_pkg.
module m64h_front
  import m64h_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] block_data_i,
  input  logic [NbW-1:0]   valid_bytes_i,
  input  logic             first_item_i,
  input  logic             last_item_i,
  input  logic [LenW-1:0]  message_length_i,
  output queue_head_t      head_o,
  input  logic             pop_i
);

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [NbW-1:0]   nb_sat;
  logic [WordW-1:0] masked;
  work_item_t       item;
  logic             in_msg_q, in_msg_d;
  logic             accept, push;

  work_item_t       mem_q [QueueDepth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign nb_sat = (valid_bytes_i > WordBytes) ? WordBytes : valid_bytes_i;

  always_comb begin
    masked = '0;
    for (int b = 0; b < 8; b++) begin
      if (NbW'(b) < nb_sat) begin
        masked[b*8 +: 8] = block_data_i[b*8 +: 8];
      end
    end
  end

  always_comb begin
    item.data   = masked;
    item.first  = first_item_i;
    item.last   = last_item_i;
    item.length = message_length_i;
    if (nb_sat == '0) begin
      item.kind = WK_NONE;
    end else if (nb_sat == WordBytes) begin
      item.kind = WK_FULL;
    end else begin
      item.kind = WK_TAIL;
    end
  end

  assign in_ready_o = (count_q != CntW'(QueueDepth));
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && (first_item_i || in_msg_q);
  assign in_msg_d   = accept ? ((first_item_i || in_msg_q) && !last_item_i) : in_msg_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(push) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      in_msg_q <= in_msg_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

FILE: src/m64h_mul.sv
// Multiplier by the MurmurHash constant, modulo 2^64, one 32x32 partial
// product per cycle: low by low, then the two cross products. Uses m64h_pkg.
module m64h_mul
  import m64h_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] opnd_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WordW-1:0] prod_o
);

  mul_step_e        step_q, step_d;
  logic             done_q, done_d;
  logic [WordW-1:0] x_q, x_d;
  logic [WordW-1:0] p_q, p_d;
  logic [31:0]      a, b;
  logic [WordW-1:0] pp;

  assign a  = (step_q == MS_MID2) ? x_q[63:32] : x_q[31:0];
  assign b  = (step_q == MS_MID1) ? MurMult[63:32] : MurMult[31:0];
  assign pp = 64'(a) * 64'(b);

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    x_d    = x_q;
    p_d    = p_q;
    unique case (step_q)
      MS_IDLE: begin
        if (start_i) begin
          x_d    = opnd_i;
          step_d = MS_LO;
        end
      end
      MS_LO: begin
        p_d    = pp;
        step_d = MS_MID1;
      end
      MS_MID1: begin
        p_d    = p_q + {pp[31:0], 32'b0};
        step_d = MS_MID2;
      end
      MS_MID2: begin
        p_d    = p_q + {pp[31:0], 32'b0};
        done_d = 1'b1;
        step_d = MS_IDLE;
      end
      default: step_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MS_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    p_q <= p_d;
  end

  assign busy_o = (step_q != MS_IDLE);
  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

FILE: src/m64h_back.sv
// Back end of the hash unit: sequencer that runs queued words through the
// shared constant multiplier and finalizes. Uses m64h_pkg and m64h_mul.
module m64h_back
  import m64h_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i,
  input  queue_head_t      head_i,
  output logic             pop_o,
  output logic             hash_valid_o,
  input  logic             hash_ready_i,
  output logic [WordW-1:0] hash_o
);

  back_state_e      state_q, state_d;
  logic [WordW-1:0] seed_q;
  logic [WordW-1:0] acc_q, acc_d;
  logic [WordW-1:0] k_q, k_d;
  work_item_t       cur_q, cur_d;

  logic             mul_start, mul_busy, mul_done, mul_state;
  logic [WordW-1:0] mul_opnd, prod;

  work_item_t       disp_item;
  logic [WordW-1:0] disp_base, disp_acc;
  back_state_e      disp_state;

  m64h_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .opnd_i (mul_opnd),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // where a word goes once the start value is known
  always_comb begin
    disp_item = (state_q == BS_IDLE) ? head_i.item : cur_q;
    disp_base = (state_q == BS_IDLE) ? acc_q : (seed_q ^ prod);
    unique case (disp_item.kind)
      WK_FULL: begin
        disp_state = BS_K_MUL1;
        disp_acc   = disp_base;
      end
      WK_TAIL: begin
        disp_state = BS_ACC_MUL;
        disp_acc   = disp_base ^ disp_item.data;
      end
      default: begin
        if (disp_item.last) begin
          disp_state = BS_FIN_MUL;
          disp_acc   = shift_xor(disp_base);
        end else begin
          disp_state = BS_IDLE;
          disp_acc   = disp_base;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (head_i.valid) begin
          state_d = head_i.item.first ? BS_LEN_MUL : disp_state;
        end
      end
      BS_LEN_MUL: if (mul_done) state_d = disp_state;
      BS_K_MUL1:  if (mul_done) state_d = BS_K_MUL2;
      BS_K_MUL2:  if (mul_done) state_d = BS_ACC_MUL;
      BS_ACC_MUL: if (mul_done) state_d = cur_q.last ? BS_FIN_MUL : BS_IDLE;
      BS_FIN_MUL: if (mul_done) state_d = BS_EMIT;
      BS_EMIT:    if (hash_ready_i) state_d = BS_IDLE;
      default:    state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    mul_state    = 1'b0;
    mul_opnd     = '0;
    pop_o        = 1'b0;
    hash_valid_o = 1'b0;
    unique case (state_q)
      BS_IDLE:    pop_o = head_i.valid;
      BS_LEN_MUL: begin
        mul_state = 1'b1;
        mul_opnd  = 64'(cur_q.length);
      end
      BS_K_MUL1: begin
        mul_state = 1'b1;
        mul_opnd  = cur_q.data;
      end
      BS_K_MUL2: begin
        mul_state = 1'b1;
        mul_opnd  = k_q;
      end
      BS_ACC_MUL, BS_FIN_MUL: begin
        mul_state = 1'b1;
        mul_opnd  = acc_q;
      end
      BS_EMIT:    hash_valid_o = 1'b1;
      default:    pop_o = 1'b0;
    endcase
    mul_start = mul_state && !mul_busy && !mul_done;
  end

  always_comb begin
    acc_d = acc_q;
    k_d   = k_q;
    cur_d = cur_q;
    unique case (state_q)
      BS_IDLE: begin
        if (head_i.valid) begin
          cur_d = head_i.item;
          if (!head_i.item.first) begin
            acc_d = disp_acc;
          end
        end
      end
      BS_LEN_MUL: if (mul_done) acc_d = disp_acc;
      BS_K_MUL1:  if (mul_done) k_d = shift_xor(prod);
      BS_K_MUL2:  if (mul_done) acc_d = acc_q ^ prod;
      BS_ACC_MUL: if (mul_done) acc_d = cur_q.last ? shift_xor(prod) : prod;
      BS_FIN_MUL: if (mul_done) acc_d = shift_xor(prod);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      seed_q  <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    cur_q <= cur_d;
  end

  assign hash_o = acc_q;

endmodule

FILE: src/murmur64a_stream_hash_unit.sv
// Top level of the MurmurHash64A stream hash unit: front end, back end and
// the output register. Uses m64h_pkg, m64h_front and m64h_back.
//
// Takes a message as little-endian 64-bit words and returns its 64-bit
// MurmurHash64A on the item marked tlast. All multiplies go through one
// shared constant multiplier that builds each product from three 32x32
// partial products; the back end runs three products for a full eight-byte
// word, one for a short tail word and none for an empty word, a first item
// adds the length product and a last item the final multiply. Up to
// QueueDepth items wait between front and back end, and the front end keeps
// taking items while a hash sits in the output register. The seed is to be
// written with cfg_we_i only while the unit is idle; this is not enforced.
module murmur64a_stream_hash_unit
  import m64h_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,     // seed
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [103:0] s_axis_tdata_i,  // block_data, valid_bytes, message_length, zero pad
  input  logic         s_axis_tuser_i,  // first_item
  input  logic         s_axis_tlast_i,  // last_item
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o   // hash_value
);

  queue_head_t      queue_head;
  logic             back_pop;
  logic             hash_valid, hash_ready;
  logic [WordW-1:0] hash;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_data_q;

  m64h_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .block_data_i    (s_axis_tdata_i[63:0]),
    .valid_bytes_i   (s_axis_tdata_i[67:64]),
    .first_item_i    (s_axis_tuser_i),
    .last_item_i     (s_axis_tlast_i),
    .message_length_i(s_axis_tdata_i[99:68]),
    .head_o          (queue_head),
    .pop_i           (back_pop)
  );

  m64h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (queue_head),
    .pop_o       (back_pop),
    .hash_valid_o(hash_valid),
    .hash_ready_i(hash_ready),
    .hash_o      (hash)
  );

  assign hash_ready  = !out_valid_q || m_axis_tready_i;
  assign out_valid_d = (hash_valid && hash_ready) ||
                       (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hash_valid && hash_ready) begin
      out_data_q <= hash;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> queue_head.valid)
    else $error("back end popped an empty queue");

  a_hash_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hash_valid && hash_ready) |=> (m_axis_tvalid_o && (m_axis_tdata_o == $past(hash))))
    else $error("finished hash not captured in output register");

  a_hash_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hash_valid && !hash_ready) |=> (hash_valid && $stable(hash)))
    else $error("finished hash changed while output register was full");

endmodule
